@@ rtl/core/kcpc_pkg.sv @@
// ----------------------------------------------------------------------------
// kcpc_pkg
// Shared constants, codes and types of the k-mer counter.
// ----------------------------------------------------------------------------
package kcpc_pkg;

    localparam int MAX_K_DEF       = 6;
    localparam int NUM_CLASSES_DEF = 4;
    localparam int KLEN_W          = 3;
    localparam int INDEX_W         = 12;
    localparam int COUNT_W         = 32;
    localparam int TAG_W           = 16;
    localparam int S_TDATA_W       = 24;
    localparam int M_TDATA_W       = 80;

    localparam logic [KLEN_W-1:0]  KLEN_RESET = 3'd3;
    localparam logic [TAG_W-1:0]   TAG_NONE   = 16'hFFFF;
    localparam logic [TAG_W-1:0]   SEQ_LAST   = 16'hFFFE;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;

    localparam logic [1:0] OP_SYMBOL = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] KIND_COUNT = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR_ALL,
        ST_TAG_CLEAR,
        ST_ISSUE,
        ST_UPDATE,
        ST_REPLY
    } state_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

endpackage

@@ rtl/core/kcpc_ram.sv @@
// ----------------------------------------------------------------------------
// kcpc_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kcpc_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/kmer_count_per_class.sv @@
// ----------------------------------------------------------------------------
// kmer_count_per_class
// Per-sequence and per-class k-mer histograms kept in block RAM.
// ----------------------------------------------------------------------------
// Count and read items: RAMs read on acceptance; the update state registers the result
// and writes count items back, waits while the output is full, and no new item is taken until it ends.
// Symbols that do not fill the window give no result; without a wrap the block stays idle.
// Clear item and reset: sweep over every address of the class RAM
// (tags and sequence bins cleared in the same pass); no items taken meanwhile.
// Sequence number wrap adds a sweep over the tag RAM, plus the ISSUE read state when counted.
module kmer_count_per_class #(
    parameter int MAX_K       = kcpc_pkg::MAX_K_DEF,
    parameter int NUM_CLASSES = kcpc_pkg::NUM_CLASSES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             kmer_length_we,
    input  logic [kcpc_pkg::KLEN_W-1:0]      kmer_length_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // symbol[1:0], first_of_sequence[2], class_id[4:3], bin_index[16:5]
    input  logic [kcpc_pkg::S_TDATA_W-1:0]   s_tdata,
    // op[1:0]
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // kmer_index[11:0], sequence_count[43:12], class_count[75:44]
    output logic [kcpc_pkg::M_TDATA_W-1:0]   m_tdata,
    // kind[1:0]
    output logic [1:0]                       m_tuser
);

    import kcpc_pkg::*;

    localparam int BIN_BITS = 2 * MAX_K;
    localparam int NUM_BINS = 1 << BIN_BITS;
    localparam int CLS_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CA_W     = CLS_W + BIN_BITS;
    localparam int CDEPTH   = NUM_CLASSES * NUM_BINS;
    localparam int FILL_W   = $clog2(MAX_K + 1);

    state_t state_reg, state_next;

    logic [KLEN_W-1:0]   klen_reg;
    logic [BIN_BITS-1:0] window_reg, window_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [TAG_W-1:0]    seq_num_reg, seq_num_next;
    logic [1:0]          op_reg;
    logic [1:0]          cls_reg;
    logic                cls_ok_reg;
    logic [BIN_BITS-1:0] bin_reg;
    logic [CA_W-1:0]     sweep_reg;
    logic                reply_reg;
    logic                result_reg;

    logic                out_valid_reg;
    logic [1:0]          out_kind_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [COUNT_W-1:0]  out_seq_reg;
    logic [COUNT_W-1:0]  out_cls_reg;

    logic [1:0]          in_op;
    logic [1:0]          in_sym;
    logic                in_first;
    logic [1:0]          in_cls;
    logic [BIN_BITS-1:0] in_rbin;
    logic                in_cls_ok;
    logic                accept;
    logic                out_free;

    logic [KLEN_W-1:0]   k_eff;
    logic [BIN_BITS-1:0] kmask;
    logic [BIN_BITS-1:0] window_base;
    logic [FILL_W-1:0]   fill_base;
    logic                seq_wrap;
    logic                counting;
    logic [BIN_BITS-1:0] bin_new;

    logic                sweep_bin_hit;
    logic                sweep_last;
    logic                tag_sweep_last;

    logic                tag_we, seq_we, cls_we;
    logic [BIN_BITS-1:0] bin_waddr, bin_raddr;
    logic [CA_W-1:0]     cls_waddr, cls_raddr;
    logic [TAG_W-1:0]    tag_wdata, tag_rdata;
    logic [COUNT_W-1:0]  seq_wdata, seq_rdata;
    logic [COUNT_W-1:0]  cls_wdata, cls_rdata;

    logic [COUNT_W-1:0]  seq_cur, seq_inc, cls_cur, cls_inc;
    logic                load_out;
    logic [1:0]          load_kind;
    logic [INDEX_W-1:0]  load_index;
    logic [COUNT_W-1:0]  load_seq, load_cls;

    assign in_sym    = s_tdata[1:0];
    assign in_first  = s_tdata[2];
    assign in_cls    = s_tdata[4:3];
    assign in_rbin   = BIN_BITS'(s_tdata[16:5]);
    assign in_op     = s_tuser;
    assign in_cls_ok = 32'(in_cls) < NUM_CLASSES;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // window arithmetic
    always_comb
    begin
        if (klen_reg == '0)
            k_eff = KLEN_W'(1);
        else if (32'(klen_reg) > MAX_K)
            k_eff = KLEN_W'(MAX_K);
        else
            k_eff = klen_reg;

        kmask       = ~({BIN_BITS{1'b1}} << {k_eff, 1'b0});
        window_base = in_first ? '0 : window_reg;
        fill_base   = in_first ? '0 : fill_reg;
        seq_wrap    = (seq_num_reg >= SEQ_LAST);
        window_next = BIN_BITS'({window_base, in_sym});
        fill_next   = (32'(fill_base) < MAX_K) ? fill_base + FILL_W'(1) : fill_base;
        counting    = 5'(fill_next) >= 5'(k_eff);
        bin_new     = window_next & kmask;
        if (in_first)
            seq_num_next = seq_wrap ? '0 : seq_num_reg + TAG_W'(1);
        else
            seq_num_next = seq_num_reg;
    end

    assign sweep_bin_hit  = (sweep_reg[CA_W-1:BIN_BITS] == '0);
    assign sweep_last     = (32'(sweep_reg) == CDEPTH - 1);
    assign tag_sweep_last = (sweep_reg[BIN_BITS-1:0] == {BIN_BITS{1'b1}});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op)
                        OP_SYMBOL:
                        begin
                            if (in_first && seq_wrap)
                                state_next = ST_TAG_CLEAR;
                            else if (counting)
                                state_next = ST_UPDATE;
                        end
                        OP_READ:  state_next = ST_UPDATE;
                        OP_CLEAR: state_next = ST_CLEAR_ALL;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR_ALL:
            begin
                if (sweep_last)
                    state_next = reply_reg ? ST_REPLY : ST_IDLE;
            end
            ST_TAG_CLEAR:
            begin
                if (tag_sweep_last)
                    state_next = result_reg ? ST_ISSUE : ST_IDLE;
            end
            ST_ISSUE:  state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_REPLY:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // RAM ports and result
    always_comb
    begin
        tag_we     = 1'b0;
        seq_we     = 1'b0;
        cls_we     = 1'b0;
        bin_waddr  = bin_reg;
        cls_waddr  = {CLS_W'(cls_reg), bin_reg};
        tag_wdata  = seq_num_reg;
        seq_wdata  = '0;
        cls_wdata  = '0;
        load_out   = 1'b0;
        load_kind  = KIND_COUNT;
        load_index = INDEX_W'(bin_reg);
        load_seq   = '0;
        load_cls   = '0;

        if (state_reg == ST_IDLE)
        begin
            bin_raddr = (in_op == OP_READ) ? in_rbin : bin_new;
            cls_raddr = {CLS_W'(in_cls), (in_op == OP_READ) ? in_rbin : bin_new};
        end
        else
        begin
            bin_raddr = bin_reg;
            cls_raddr = {CLS_W'(cls_reg), bin_reg};
        end

        seq_cur = (tag_rdata == seq_num_reg) ? seq_rdata : '0;
        seq_inc = sat_inc(seq_cur);
        cls_cur = cls_ok_reg ? cls_rdata : '0;
        cls_inc = cls_ok_reg ? sat_inc(cls_rdata) : '0;

        unique case (state_reg)
            ST_CLEAR_ALL:
            begin
                bin_waddr = sweep_reg[BIN_BITS-1:0];
                cls_waddr = sweep_reg;
                tag_wdata = TAG_NONE;
                tag_we    = sweep_bin_hit;
                seq_we    = sweep_bin_hit;
                cls_we    = 1'b1;
            end
            ST_TAG_CLEAR:
            begin
                bin_waddr = sweep_reg[BIN_BITS-1:0];
                tag_wdata = TAG_NONE;
                tag_we    = 1'b1;
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (op_reg == OP_READ)
                    begin
                        load_kind = KIND_READ;
                        load_seq  = seq_cur;
                        load_cls  = cls_cur;
                    end
                    else
                    begin
                        load_kind = KIND_COUNT;
                        load_seq  = seq_inc;
                        load_cls  = cls_inc;
                        seq_wdata = seq_inc;
                        cls_wdata = cls_inc;
                        tag_we    = 1'b1;
                        seq_we    = 1'b1;
                        cls_we    = cls_ok_reg;
                    end
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    load_kind  = KIND_CLEAR;
                    load_index = '0;
                end
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR_ALL;
            klen_reg      <= KLEN_RESET;
            window_reg    <= '0;
            fill_reg      <= '0;
            seq_num_reg   <= '0;
            sweep_reg     <= '0;
            reply_reg     <= 1'b0;
            result_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (kmer_length_we)
                klen_reg <= kmer_length_wdata;

            if (accept)
            begin
                op_reg     <= in_op;
                cls_reg    <= in_cls;
                cls_ok_reg <= in_cls_ok;
                bin_reg    <= (in_op == OP_READ) ? in_rbin : bin_new;
                sweep_reg  <= '0;
                reply_reg  <= 1'b1;
                result_reg <= counting;
                if (in_op == OP_SYMBOL)
                begin
                    window_reg  <= window_next;
                    fill_reg    <= fill_next;
                    seq_num_reg <= seq_num_next;
                end
            end
            else if (state_reg == ST_CLEAR_ALL || state_reg == ST_TAG_CLEAR)
            begin
                sweep_reg <= sweep_reg + CA_W'(1);
            end

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_kind_reg  <= load_kind;
            out_index_reg <= load_index;
            out_seq_reg   <= load_seq;
            out_cls_reg   <= load_cls;
        end
    end

    kcpc_ram #(
        .WIDTH  (TAG_W),
        .DEPTH  (NUM_BINS),
        .ADDR_W (BIN_BITS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_we),
        .wr_addr (bin_waddr),
        .wr_data (tag_wdata),
        .rd_addr (bin_raddr),
        .rd_data (tag_rdata)
    );

    kcpc_ram #(
        .WIDTH  (COUNT_W),
        .DEPTH  (NUM_BINS),
        .ADDR_W (BIN_BITS)
    ) u_seq_ram (
        .clk     (clk),
        .wr_en   (seq_we),
        .wr_addr (bin_waddr),
        .wr_data (seq_wdata),
        .rd_addr (bin_raddr),
        .rd_data (seq_rdata)
    );

    kcpc_ram #(
        .WIDTH  (COUNT_W),
        .DEPTH  (CDEPTH),
        .ADDR_W (CA_W)
    ) u_cls_ram (
        .clk     (clk),
        .wr_en   (cls_we),
        .wr_addr (cls_waddr),
        .wr_data (cls_wdata),
        .rd_addr (cls_raddr),
        .rd_data (cls_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = M_TDATA_W'({out_cls_reg, out_seq_reg, out_index_reg});

endmodule
